>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the edge magnitude block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define SOBEL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition never seen at an edge outside reset
`define SOBEL_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// types, codes and helper functions of the rgb sobel edge magnitude block
// ----------------------------------------------------------------------------
package sobel_pkg;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

  // input item kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // magnitude saturation
  localparam logic [20:0] SAT_LIMIT = 21'd65281;
  localparam logic [7:0]  EDGE_MAX  = 8'd255;
  localparam logic [7:0]  ROOT_FIRST_BIT = 8'h80;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic div_start;  // start a counter division
    logic div_sel;    // 0: pixel counter, 1: result counter
    logic update;     // line stores, window and pixel counter
    logic grad;       // gradients and result counters
    logic square;     // sums of squares, root init
    logic root_step;  // one bit of the roots
    logic round;      // rounding into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sync_needed;  // column counters stale after a size write
    logic div_done;     // division finishes this cycle
    logic ignore;       // drain tick inside the frame
    logic due;          // this item releases a result
    logic root_last;    // last root bit this cycle
  } status_t;

  // 3x3 gradient, horizontal: right column minus left column
  function automatic logic signed [10:0] grad_x(input logic [8:0][7:0] p);
    logic [10:0] pos;
    logic [10:0] neg;
    pos = 11'(p[2]) + (11'(p[5]) << 1) + 11'(p[8]);
    neg = 11'(p[0]) + (11'(p[3]) << 1) + 11'(p[6]);
    return signed'(pos - neg);
  endfunction

  // 3x3 gradient, vertical: bottom row minus top row
  function automatic logic signed [10:0] grad_y(input logic [8:0][7:0] p);
    logic [10:0] pos;
    logic [10:0] neg;
    pos = 11'(p[6]) + (11'(p[7]) << 1) + 11'(p[8]);
    neg = 11'(p[0]) + (11'(p[1]) << 1) + 11'(p[2]);
    return signed'(pos - neg);
  endfunction

endpackage

>>> rtl/sobel_pix_if.sv
// ----------------------------------------------------------------------------
// sobel_pix_if
// pixel input channel: valid, ready and one pixel or drain tick
// ----------------------------------------------------------------------------
interface sobel_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;

  modport source (output valid, req_type, pix_red, pix_green, pix_blue, input ready);
  modport sink   (input valid, req_type, pix_red, pix_green, pix_blue, output ready);
endinterface

>>> rtl/sobel_edge_if.sv
// ----------------------------------------------------------------------------
// sobel_edge_if
// result channel: valid, ready, frame_end and the red, green and blue edge magnitudes
// ----------------------------------------------------------------------------
interface sobel_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

>>> rtl/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sobel_ctrl.sv
// ----------------------------------------------------------------------------
// sobel_ctrl
// sequencer: steps one item through resync, line store, gradient and root
// ----------------------------------------------------------------------------
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIVP   = 10'b0000000010,
    S_DIVR   = 10'b0000000100,
    S_READ   = 10'b0000001000,
    S_UPDATE = 10'b0000010000,
    S_GRAD   = 10'b0000100000,
    S_SQUARE = 10'b0001000000,
    S_ROOT   = 10'b0010000000,
    S_ROUND  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (st.sync_needed) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIVP;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_DIVP: begin
        if (st.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIVR;
        end
      end
      S_DIVR: begin
        cmd.div_sel = 1'b1;
        if (st.div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = st.ignore ? S_IDLE : S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = st.due ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (st.root_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sobel_dp.sv
// ----------------------------------------------------------------------------
// sobel_dp
// datapath: size registers, counters, line stores, window, gradients, roots
// ----------------------------------------------------------------------------
module sobel_dp
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output status_t          st,
  input  logic             req_type,
  input  logic [7:0]       pix_red,
  input  logic [7:0]       pix_green,
  input  logic [7:0]       pix_blue,
  output logic [7:0]       edge_red,
  output logic [7:0]       edge_green,
  output logic [7:0]       edge_blue,
  output logic             frame_end
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HID_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int unsigned WCMP  = (WID_W > CFG_W) ? WID_W : CFG_W;
  localparam int unsigned HCMP  = (HID_W > CFG_W) ? HID_W : CFG_W;
  localparam int unsigned DCW   = $clog2(CNT_W + 1);

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [WID_W-1:0] w;
  logic [HID_W-1:0] h;
  logic [WID_W-1:0] w_next;
  logic [HID_W-1:0] h_next;
  logic [CNT_W-1:0] n;

  logic [CNT_W-1:0] pt;
  logic [CNT_W-1:0] rg;
  logic [AW-1:0]    col;
  logic [AW-1:0]    oc;
  logic [CNT_W-1:0] orow;
  logic             sync;

  logic             req;
  logic [23:0]      pix;
  logic [23:0]      pix_eff;
  logic [23:0]      rd_up;
  logic [23:0]      rd_mid;
  logic [23:0]      win [9];

  logic [CNT_W-1:0] dvd;
  logic [WID_W-1:0] rem;
  logic [CNT_W-1:0] quo;
  logic [DCW-1:0]   dcnt;
  logic             div_rg;
  logic [WID_W:0]   rem_sh;
  logic             rem_ge;
  logic [WID_W-1:0] rem_n;
  logic [CNT_W-1:0] quo_n;

  logic             in_frame;
  logic             last;
  logic             last_flag;
  logic             col_wrap;
  logic             oc_wrap;
  logic             off_top;
  logic             off_bot;
  logic             off_left;
  logic             off_right;
  logic [8:0][7:0]  pb [3];

  logic signed [10:0] gx [3];
  logic signed [10:0] gy [3];
  logic [20:0]        s [3];
  logic [7:0]         r [3];
  logic [7:0]         rbit;
  logic [7:0]         res [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= FRAME_WIDTH_RESET;
      cfg_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped frame sizes and pixel count
  always_comb begin
    if (cfg_width == '0) begin
      w_next = WID_W'(1);
    end else if (WCMP'(cfg_width) > WCMP'(MAX_WIDTH)) begin
      w_next = WID_W'(MAX_WIDTH);
    end else begin
      w_next = WID_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_next = HID_W'(1);
    end else if (HCMP'(cfg_height) > HCMP'(MAX_HEIGHT)) begin
      h_next = HID_W'(MAX_HEIGHT);
    end else begin
      h_next = HID_W'(cfg_height);
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    h <= h_next;
    n <= CNT_W'(w_next * h_next);
  end

  // status
  assign in_frame = pt < n;
  assign pix_eff  = in_frame ? pix : '0;
  assign last     = (CNT_W + 1)'(rg) + 1'b1 >= (CNT_W + 1)'(n);
  assign col_wrap = WID_W'(col) + 1'b1 == w;
  assign oc_wrap  = WID_W'(oc) + 1'b1 == w;

  always_comb begin
    st             = '0;
    st.sync_needed = sync;
    st.div_done    = dcnt == DCW'(1);
    st.ignore      = in_frame && (req == REQ_DRAIN);
    st.due         = (CNT_W + 2)'(pt) >= (CNT_W + 2)'(rg) + (CNT_W + 2)'(w) + 1'b1;
    st.root_last   = rbit[0];
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem, dvd[CNT_W-1]};
  assign rem_ge = rem_sh >= (WID_W + 1)'(w);
  assign rem_n  = rem_ge ? WID_W'(rem_sh - (WID_W + 1)'(w)) : WID_W'(rem_sh);
  assign quo_n  = {quo[CNT_W-2:0], rem_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCW'(CNT_W);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  // dividend load and shift, and which counter the running division belongs to
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd    <= cmd.div_sel ? rg : pt;
      div_rg <= cmd.div_sel;
      rem    <= '0;
      quo    <= '0;
    end else begin
      dvd <= dvd << 1;
      rem <= rem_n;
      quo <= quo_n;
    end
  end

  // captured input item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_type;
      pix <= {pix_red, pix_green, pix_blue};
    end
  end

  // line stores
  sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (col),
    .wdata (rd_mid),
    .raddr (col),
    .rdata (rd_up)
  );

  sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (col),
    .wdata (pix_eff),
    .raddr (col),
    .rdata (rd_mid)
  );

  // 3x3 window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (cmd.update) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]     <= win[k*3+1];
        win[k*3+1]   <= win[k*3+2];
      end
      win[2] <= rd_up;
      win[5] <= rd_mid;
      win[8] <= pix_eff;
    end
  end

  // frame counters and resync of column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pt        <= '0;
      rg        <= '0;
      col       <= '0;
      oc        <= '0;
      orow      <= '0;
      sync      <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      if (cfg_write) begin
        sync <= 1'b1;
      end else if (st.div_done && div_rg) begin
        sync <= 1'b0;
      end
      if (st.div_done) begin
        if (div_rg) begin
          oc   <= AW'(rem_n);
          orow <= quo_n;
        end else begin
          col <= AW'(rem_n);
        end
      end
      if (cmd.update) begin
        pt  <= pt + 1'b1;
        col <= col_wrap ? '0 : col + 1'b1;
      end
      if (cmd.grad) begin
        last_flag <= last;
        if (last) begin
          pt   <= '0;
          rg   <= '0;
          col  <= '0;
          oc   <= '0;
          orow <= '0;
        end else begin
          rg <= rg + 1'b1;
          if (oc_wrap) begin
            oc   <= '0;
            orow <= orow + 1'b1;
          end else begin
            oc <= oc + 1'b1;
          end
        end
      end
    end
  end

  // window masked at the frame border
  assign off_top   = orow == '0;
  assign off_bot   = (CNT_W + 1)'(orow) + 1'b1 >= (CNT_W + 1)'(h);
  assign off_left  = oc == '0;
  assign off_right = WID_W'(oc) + 1'b1 >= w;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        if ((k < 3 && off_top) || (k >= 6 && off_bot) ||
            (k % 3 == 0 && off_left) || (k % 3 == 2 && off_right)) begin
          pb[ch][k] = '0;
        end else begin
          pb[ch][k] = win[k][(2-ch)*8 +: 8];
        end
      end
    end
  end

  // gradients, squares and bitwise root per channel
  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx[ch] <= grad_x(pb[ch]);
        gy[ch] <= grad_y(pb[ch]);
      end
    end
    if (cmd.square) begin
      for (int ch = 0; ch < 3; ch++) begin
        s[ch] <= 21'(22'(gx[ch] * gx[ch])) + 21'(22'(gy[ch] * gy[ch]));
        r[ch] <= '0;
      end
      rbit <= ROOT_FIRST_BIT;
    end
    if (cmd.root_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (21'((r[ch] | rbit) * (r[ch] | rbit)) <= s[ch]) begin
          r[ch] <= r[ch] | rbit;
        end
      end
      rbit <= rbit >> 1;
    end
  end

  // rounding and saturation
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (s[ch] >= SAT_LIMIT) begin
        res[ch] = EDGE_MAX;
      end else if (s[ch] > 21'(17'(r[ch] * r[ch]) + 17'(r[ch]))) begin
        res[ch] = r[ch] + 1'b1;
      end else begin
        res[ch] = r[ch];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      edge_red   <= res[0];
      edge_green <= res[1];
      edge_blue  <= res[2];
      frame_end  <= last_flag;
    end
  end

endmodule

>>> rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 sobel gradient magnitude on rgb pixels in raster order
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  pix_in   in   valid / ready        req_type, pix_red, pix_green, pix_blue
//  edge_out out  valid / ready        edge_red, edge_green, edge_blue, frame_end
//  cfg      in   cfg_write            cfg_index, cfg_data
//
//  a drain tick inside the frame goes through read and back to idle, any other
//  item through read and update; one with a result also through gradient,
//  square, the 8 step bitwise root, rounding and the output handshake
//  the first item after a size write adds 2 divisions before its read
//  synchronous reset returns the sequencer to idle, counters and window to zero
//  a stalled result holds the block: pix_in.ready is low until it is taken
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  sobel_pix_if.sink          pix_in,
  sobel_edge_if.source       edge_out,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t st;

  // sequencer
  sobel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (edge_out.valid),
    .out_ready (edge_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  sobel_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .req_type   (pix_in.req_type),
    .pix_red    (pix_in.pix_red),
    .pix_green  (pix_in.pix_green),
    .pix_blue   (pix_in.pix_blue),
    .edge_red   (edge_out.edge_red),
    .edge_green (edge_out.edge_green),
    .edge_blue  (edge_out.edge_blue),
    .frame_end  (edge_out.frame_end)
  );

endmodule

>>> rtl/sobel_chk.sv
// ----------------------------------------------------------------------------
// sobel_chk
// port level checks of the edge magnitude block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] edge_red,
  input logic [7:0] edge_green,
  input logic [7:0] edge_blue,
  input logic       frame_end
);

  // a waiting result stays offered
  `SOBEL_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // a waiting result keeps its value
  `SOBEL_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(edge_red) && $stable(edge_green) && $stable(edge_blue) && $stable(frame_end), "result changed while stalled")

  // no new item is taken while a result waits
  `SOBEL_NEVER(a_one_item, clk, rst, in_ready && out_valid, "input open while result pending")

  // once a result is taken the block is ready for the next item
  `SOBEL_ASSERT(a_ready_after, clk, rst, out_valid && out_ready |=> in_ready && !out_valid, "not ready after result")

  // a taken item closes the input for the next cycle
  `SOBEL_ASSERT(a_busy_after_take, clk, rst, in_valid && in_ready |=> !in_ready, "input open right after an item")

endmodule

bind sobel_edge_magnitude_rgb sobel_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (edge_out.valid),
  .out_ready  (edge_out.ready),
  .edge_red   (edge_out.edge_red),
  .edge_green (edge_out.edge_green),
  .edge_blue  (edge_out.edge_blue),
  .frame_end  (edge_out.frame_end)
);

>>> bench/sobel_edge_magnitude_rgb_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb
// streams small rgb frames, drain ticks and stray items into the edge block
// and checks every result against a cycle-free sobel magnitude predictor;
// a short directed table opens the run, random frames of random size follow
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;
  import sobel_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 1024;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_item_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_DRAIN} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       reg_idx;
    logic [10:0] reg_val;
    logic [23:0] rgb;
    logic       has_exp;
    edge_item_t exp;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sobel_pix_if  pix ();
  sobel_edge_if eo ();

  sobel_edge_magnitude_rgb #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix.sink),
    .edge_out (eo.source),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [23:0] upper_line [MAX_W];
  logic [23:0] middle_line [MAX_W];
  logic [23:0] win_q [9];
  int unsigned taken_cnt;
  int unsigned given_cnt;
  logic [10:0] width_reg;
  logic [10:0] height_reg;

  edge_item_t edge_q[$];
  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned send_idle;
  int unsigned recv_idle;
  dir_row_t dir_tab [DIR_ROWS];

  function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // rounded integer root, saturating at the top
  function automatic logic [7:0] round_root(input int unsigned s);
    int unsigned r;
    int unsigned t;
    r = 0;
    if (s >= SAT_LIMIT) return EDGE_MAX;
    for (int b = 7; b >= 0; b--) begin
      t = r + (1 << b);
      if (t * t <= s) r = t;
    end
    if (s > r * r + r) r++;
    return (r > 255) ? EDGE_MAX : 8'(r);
  endfunction

  function automatic logic [7:0] edge_mag(input logic [23:0] m [9], input int sh);
    int p [9];
    int gx;
    int gy;
    for (int i = 0; i < 9; i++) p[i] = (m[i] >> sh) & 8'hFF;
    gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
    gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
    return round_root(gx * gx + gy * gy);
  endfunction

  // advance the predicted block by one accepted item
  function automatic bit sobel_predict(input logic req, input logic [23:0] rgb,
                                       output edge_item_t res);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned col;
    int unsigned oc;
    int unsigned orow;
    logic [23:0] px;
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] masked [9];
    bit off;
    bit last;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    n = w * h;
    px = '0;
    res = '0;
    if (taken_cnt < n) begin
      if (req == REQ_DRAIN) return 0;
      px = rgb;
    end
    col = taken_cnt % w;
    top = upper_line[col];
    mid = middle_line[col];
    upper_line[col] = mid;
    middle_line[col] = px;
    for (int r = 0; r < 3; r++) begin
      win_q[r*3] = win_q[r*3+1];
      win_q[r*3+1] = win_q[r*3+2];
    end
    win_q[2] = top;
    win_q[5] = mid;
    win_q[8] = px;
    taken_cnt++;
    if (taken_cnt < given_cnt + w + 2) return 0;
    oc = given_cnt % w;
    orow = given_cnt / w;
    // zero the neighbors outside the frame
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        off = (r == 0 && orow == 0) || (r == 2 && orow + 1 >= h) ||
              (c == 0 && oc == 0) || (c == 2 && oc + 1 >= w);
        masked[r*3+c] = off ? 24'd0 : win_q[r*3+c];
      end
    end
    res.red = edge_mag(masked, 16);
    res.green = edge_mag(masked, 8);
    res.blue = edge_mag(masked, 0);
    last = (given_cnt + 1 >= n);
    res.frame_end = last;
    if (last) begin
      taken_cnt = 0;
      given_cnt = 0;
    end else begin
      given_cnt++;
    end
    return 1;
  endfunction

  // result side: check and random stall
  always @(posedge clk) begin
    edge_item_t got;
    edge_item_t want;
    if (!rst && eo.valid && eo.ready) begin
      got = '{eo.edge_red, eo.edge_green, eo.edge_blue, eo.frame_end};
      if (edge_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: %p", got);
      end else begin
        want = edge_q.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    eo.ready <= ($urandom_range(99) >= recv_idle);
  end

  // one item through the input handshake, then into the predictor
  task automatic put_item(input logic req, input logic [23:0] rgb,
                          input bit has_exp = 0, input edge_item_t exp = '0);
    edge_item_t res;
    while ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.req_type <= req;
    {pix.pix_red, pix.pix_green, pix.pix_blue} <= rgb;
    do @(posedge clk); while (!pix.ready);
    sent_cnt++;
    if (sobel_predict(req, rgb, res)) edge_q.push_back(has_exp ? exp : res);
  endtask

  // register write once the block has gone quiet
  task automatic reg_write(input logic idx, input logic [10:0] val);
    pix.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // a full frame with stray drain ticks, then the draining tail
  task automatic run_frame(input logic [10:0] w_val, input logic [10:0] h_val,
                           input int unsigned noise_pct);
    int unsigned w;
    int unsigned n;
    reg_write(REG_FRAME_WIDTH, w_val);
    reg_write(REG_FRAME_HEIGHT, h_val);
    w = clamp_size(w_val, MAX_W);
    n = w * clamp_size(h_val, MAX_H);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) put_item(REQ_DRAIN, 24'($urandom));
      put_item(REQ_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
    end
    // tail: pixels past the end act as drain ticks
    for (int unsigned i = 0; i <= w; i++)
      put_item(($urandom_range(3) == 0) ? REQ_PIXEL : REQ_DRAIN, 24'($urandom));
  endtask

  initial begin
    edge_item_t zero_end;
    zero_end = '{8'd0, 8'd0, 8'd0, 1'b1};
    dir_tab = '{
      '{ROW_CFG,   REG_FRAME_WIDTH,  11'd1, 24'h0, 1'b0, '0},
      '{ROW_CFG,   REG_FRAME_HEIGHT, 11'd1, 24'h0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'hFF0080, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h010203, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b1, zero_end},
      '{ROW_CFG,   REG_FRAME_WIDTH,  11'd0, 24'h0, 1'b0, '0},
      '{ROW_CFG,   REG_FRAME_HEIGHT, 11'd0, 24'h0, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h00FFFF, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b1, zero_end},
      '{ROW_CFG,   REG_FRAME_WIDTH,  11'd3, 24'h0, 1'b0, '0},
      '{ROW_CFG,   REG_FRAME_HEIGHT, 11'd2, 24'h0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h000000, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h000000, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'hFF00FF, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h00FF00, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b0, '0},
      '{ROW_PIXEL, 1'b0, 11'd0, 24'h123456, 1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b0, '0},
      '{ROW_DRAIN, 1'b0, 11'd0, 24'h0,      1'b0, '0}
    };

    // predictor reset
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (win_q[i]) win_q[i] = '0;
    taken_cnt = 0;
    given_cnt = 0;
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    err_cnt = 0;
    sent_cnt = 0;
    send_idle = 28;
    recv_idle = 68;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.req_type = REQ_PIXEL;
    pix.pix_red = '0;
    pix.pix_green = '0;
    pix.pix_blue = '0;
    eo.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
        ROW_PIXEL: put_item(REQ_PIXEL, dir_tab[i].rgb, dir_tab[i].has_exp, dir_tab[i].exp);
        default: put_item(REQ_DRAIN, dir_tab[i].rgb, dir_tab[i].has_exp, dir_tab[i].exp);
      endcase
    end

    // random frames, idle pattern changes by thirds of the items sent
    while (sent_cnt < 650) begin
      if (sent_cnt >= 433) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent_cnt >= 217) begin
        send_idle = 68;
        recv_idle = 28;
      end
      run_frame(11'($urandom_range(1, 8)), 11'($urandom_range(1, 6)), 8);
    end

    pix.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("sobel_edge_magnitude_rgb_tb: done, clean");
    end else begin
      $display("sobel_edge_magnitude_rgb_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("sobel_edge_magnitude_rgb_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sobel_pkg.sv
rtl/sobel_pix_if.sv
rtl/sobel_edge_if.sv
rtl/sobel_ram.sv
rtl/sobel_ctrl.sv
rtl/sobel_dp.sv
rtl/sobel_edge_magnitude_rgb.sv
rtl/sobel_chk.sv
bench/sobel_edge_magnitude_rgb_tb.sv
